[sv/mdu_pkg.sv]
// Shared types and constants of the multiply/divide unit.
package mdu_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ITER_COUNT = DATA_W;
	localparam int unsigned CNT_W = $clog2(ITER_COUNT);

	localparam logic [2:0] FN_MULT  = 3'd0;
	localparam logic [2:0] FN_MULTU = 3'd1;
	localparam logic [2:0] FN_DIV   = 3'd2;
	localparam logic [2:0] FN_DIVU  = 3'd3;
	localparam logic [2:0] FN_MFHI  = 3'd4;
	localparam logic [2:0] FN_MFLO  = 3'd5;
	localparam logic [2:0] FN_MTHI  = 3'd6;
	localparam logic [2:0] FN_MTLO  = 3'd7;

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] ONE_WORD = DATA_W'(1);

	typedef struct packed {
		logic start;
		logic is_div;
	} core_ctl_t;

	typedef struct packed {
		logic                done;
		logic [DATA_W-1:0]   hi;
		logic [DATA_W-1:0]   lo;
	} core_stat_t;

endpackage

[sv/mdu_core.sv]
// Radix-2 shift-add multiplier and restoring divider on one shared adder.
module mdu_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mdu_pkg::core_ctl_t            ctl,
	input  logic [mdu_pkg::DATA_W-1:0]    a_mag,
	input  logic [mdu_pkg::DATA_W-1:0]    b_mag,
	output mdu_pkg::core_stat_t           stat
);

	localparam int unsigned W = mdu_pkg::DATA_W;

	logic                        busy_q;
	logic                        is_div_q;
	logic [mdu_pkg::CNT_W-1:0]   cnt_q;
	logic [W-1:0]                acc_q;
	logic [W-1:0]                sh_q;
	logic [W-1:0]                m_q;

	logic [W+1:0]                add_x;
	logic [W+1:0]                add_y;
	logic [W+1:0]                sum;
	logic                        fits;
	logic                        last;

	// Shared adder: add multiplicand on a set multiplier bit, or subtract the divisor
	always_comb begin
		if (is_div_q) begin
			add_x = {1'b0, acc_q, sh_q[W-1]};
			add_y = ~{2'b00, m_q};
		end else begin
			add_x = {2'b00, acc_q};
			add_y = sh_q[0] ? {2'b00, m_q} : '0;
		end
		sum  = add_x + add_y + {{(W+1){1'b0}}, is_div_q};
		fits = ~sum[W+1];
	end

	assign last = busy_q && (cnt_q == mdu_pkg::CNT_W'(mdu_pkg::ITER_COUNT - 1));

	// Sequence control: load on start, run a fixed number of steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: partial product or partial remainder in acc, multiplier or quotient in sh
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			is_div_q <= ctl.is_div;
			acc_q    <= '0;
			sh_q     <= ctl.is_div ? a_mag : b_mag;
			m_q      <= ctl.is_div ? b_mag : a_mag;
		end else if (busy_q) begin
			if (is_div_q) begin
				acc_q <= fits ? sum[W-1:0] : add_x[W-1:0];
				sh_q  <= {sh_q[W-2:0], fits};
			end else begin
				acc_q <= sum[W:1];
				sh_q  <= {sum[0], sh_q[W-1:1]};
			end
		end
	end

	assign stat.done = last;
	assign stat.hi   = acc_q;
	assign stat.lo   = sh_q;

endmodule

[sv/multiply_divide_unit.sv]
// Top level of the multiply/divide unit holding HI and LO.
// For MULT, MULTU, DIV and DIVU the operand magnitudes load into the iteration core
// at the accepting edge; then follow 32 steps of the shared 34-bit adder, the fixup
// state for sign and divide-by-zero, and the final state that writes the result.
// MFHI, MFLO, MTHI and MTLO go from acceptance straight to the final state. The
// unit takes one word at a time; the next word is accepted in the cycle after a
// result is registered, and a result may wait in the output register while the
// next word computes (completion then holds until the output register is free).
module multiply_divide_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    func,
	input  logic [mdu_pkg::DATA_W-1:0]    rs_value,
	input  logic [mdu_pkg::DATA_W-1:0]    rt_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mdu_pkg::DATA_W-1:0]    read_value,
	output logic [mdu_pkg::DATA_W-1:0]    hi_value,
	output logic [mdu_pkg::DATA_W-1:0]    lo_value
);

	localparam int unsigned W = mdu_pkg::DATA_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [W-1:0]          hi_q;
	logic [W-1:0]          lo_q;

	logic                  is_signed_q;
	logic                  is_div_q;
	logic                  neg_a_q;
	logic                  neg_b_q;
	logic                  div_zero_q;
	logic [W-1:0]          rs_q;
	logic [W-1:0]          res_rd_q;
	logic [W-1:0]          res_hi_q;
	logic [W-1:0]          res_lo_q;

	logic                  out_valid_q;
	logic [W-1:0]          out_rd_q;
	logic [W-1:0]          out_hi_q;
	logic [W-1:0]          out_lo_q;

	logic                  accept;
	logic                  out_free;
	logic                  is_arith;
	logic                  is_signed;
	logic                  is_div;
	logic [W-1:0]          a_mag;
	logic [W-1:0]          b_mag;
	logic [2*W-1:0]        prod_neg;
	logic [W-1:0]          q_fix;
	logic [W-1:0]          r_fix;

	mdu_pkg::core_ctl_t    core_ctl;
	mdu_pkg::core_stat_t   core_stat;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Decode the operation and take operand magnitudes for signed forms
	always_comb begin
		case (func) inside
			mdu_pkg::FN_MULT, mdu_pkg::FN_MULTU, mdu_pkg::FN_DIV, mdu_pkg::FN_DIVU:
				is_arith = 1'b1;
			default:
				is_arith = 1'b0;
		endcase
		is_signed = (func == mdu_pkg::FN_MULT) || (func == mdu_pkg::FN_DIV);
		is_div    = (func == mdu_pkg::FN_DIV) || (func == mdu_pkg::FN_DIVU);
		a_mag     = (is_signed && rs_value[W-1]) ? (~rs_value + 1'b1) : rs_value;
		b_mag     = (is_signed && rt_value[W-1]) ? (~rt_value + 1'b1) : rt_value;
	end

	assign core_ctl.start  = accept && is_arith;
	assign core_ctl.is_div = is_div;

	mdu_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.a_mag  (a_mag),
		.b_mag  (b_mag),
		.stat   (core_stat)
	);

	// Sign fixup of the raw core result
	always_comb begin
		prod_neg = ~{core_stat.hi, core_stat.lo} + 1'b1;
		q_fix    = (neg_a_q != neg_b_q) ? (~core_stat.lo + 1'b1) : core_stat.lo;
		r_fix    = neg_a_q ? (~core_stat.hi + 1'b1) : core_stat.hi;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= is_arith ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (core_stat.done) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold operation flags and build the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			is_signed_q <= is_signed;
			is_div_q    <= is_div;
			neg_a_q     <= is_signed && rs_value[W-1];
			neg_b_q     <= is_signed && rt_value[W-1];
			div_zero_q  <= (rt_value == '0);
			rs_q        <= rs_value;
			res_rd_q    <= (func == mdu_pkg::FN_MFHI) ? hi_q :
			               (func == mdu_pkg::FN_MFLO) ? lo_q : '0;
			res_hi_q    <= (func == mdu_pkg::FN_MTHI) ? rs_value : hi_q;
			res_lo_q    <= (func == mdu_pkg::FN_MTLO) ? rs_value : lo_q;
		end else if (state_q == ST_FIX) begin
			if (!is_div_q) begin
				if (neg_a_q != neg_b_q) begin
					{res_hi_q, res_lo_q} <= prod_neg;
				end else begin
					{res_hi_q, res_lo_q} <= {core_stat.hi, core_stat.lo};
				end
			end else if (div_zero_q) begin
				res_hi_q <= rs_q;
				res_lo_q <= (is_signed_q && neg_a_q) ? mdu_pkg::ONE_WORD : mdu_pkg::ALL_ONES;
			end else begin
				res_hi_q <= r_fix;
				res_lo_q <= q_fix;
			end
		end
	end

	// Commit HI and LO when the result word is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if ((state_q == ST_FIN) && out_free) begin
			hi_q <= res_hi_q;
			lo_q <= res_lo_q;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_rd_q <= res_rd_q;
			out_hi_q <= res_hi_q;
			out_lo_q <= res_lo_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_rd_q;
	assign hi_value   = out_hi_q;
	assign lo_value   = out_lo_q;

endmodule
